@@ sv/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the bounded life grid generation step.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = ROW_W + 1;
  localparam int CFG_W     = 7;
  localparam int ROW_IDX_W = 6;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic {
    CFG_ACTIVE_ROWS = 1'b0,
    CFG_ACTIVE_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [MAX_COLS-1:0]    row_cells;
  } in_t;

  typedef struct packed {
    logic [MAX_COLS-1:0] read_cells;
    logic                is_read_data;
  } out_t;

endpackage

`default_nettype wire

@@ sv/lgs_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/lgs_lane.sv @@
// ----------------------------------------------------------------------------
// lgs_lane
// One column of the generation rule: B3/S23 over a 3x3 neighbourhood.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_lane (
  input  wire logic [2:0] above,
  input  wire logic [2:0] cur,
  input  wire logic [2:0] below,
  output      logic       next_cell
);

  logic [3:0] cnt;

  always_comb begin
    cnt = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
        + 4'(below[0]) + 4'(below[1]) + 4'(below[2])
        + 4'(cur[0]) + 4'(cur[2]);
    next_cell = (cnt == 4'd3) || ((cnt == 4'd2) && cur[1]);
  end

endmodule

`default_nettype wire

@@ sv/life_grid_generation_step.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded B3/S23 grid: load a row, advance one generation, or read a row.
//
//   channel  ports                                     direction
//   input    start, busy, in_word                      in (busy out)
//   result   out_strobe, out_word                      out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// load and unused opcode: result strobed the cycle after accept, no busy
// read: busy in ST_RDW, result registered from the RAM read in ST_RDW
// advance: busy while k_r steps from 0 to MAX_ROWS, one row per cycle through the grid RAM
//   read port, all columns of a row computed by parallel lanes
// reset clears per-row valid bits at once, no clearing pass
// results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output      logic            busy,
  input  wire lgs_pkg::in_t    in_word,
  output      logic            out_strobe,
  output      lgs_pkg::out_t   out_word,
  input  wire logic            cfg_valid,
  output      logic            cfg_ready,
  input  wire lgs_pkg::cfg_idx_t cfg_index,
  input  wire logic [lgs_pkg::CFG_W-1:0] cfg_data
);

  import lgs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RDW  = 3'b010,
    ST_ADV  = 3'b100
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    active_rows_r;
  logic [CFG_W-1:0]    active_cols_r;
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [CNT_W-1:0]    k_r;
  logic [MAX_COLS-1:0] above_r;
  logic [MAX_COLS-1:0] cur_r;
  logic                rd_ok_r;
  logic                out_strobe_r;
  out_t                out_word_r;

  logic [CFG_W-1:0]    eff_rows;
  logic [CFG_W-1:0]    eff_cols;
  logic [MAX_COLS-1:0] col_mask;
  logic                accept;
  logic                in_inside;
  logic [CNT_W-1:0]    wrow;
  logic [MAX_COLS-1:0] below_word;
  logic [MAX_COLS-1:0] lane_out;
  logic [MAX_COLS-1:0] row_next;
  logic [MAX_COLS+1:0] pad_above;
  logic [MAX_COLS+1:0] pad_cur;
  logic [MAX_COLS+1:0] pad_below;

  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [ROW_W-1:0]    ram_raddr;
  logic [MAX_COLS-1:0] ram_rdata;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  always_comb begin
    eff_rows = (active_rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : active_rows_r;
    eff_cols = (active_cols_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : active_cols_r;
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (CFG_W'(j) < eff_cols);
    end
  end

  assign in_inside = (CFG_W'(in_word.row_index) < eff_rows);
  assign wrow      = k_r - CNT_W'(1);

  // row arriving from the RAM this cycle, zero outside the active region or if never loaded
  assign below_word = ((CFG_W'(k_r) < eff_rows) && row_vld_r[k_r[ROW_W-1:0]])
                    ? (ram_rdata & col_mask) : '0;

  assign pad_above = {1'b0, above_r, 1'b0};
  assign pad_cur   = {1'b0, cur_r, 1'b0};
  assign pad_below = {1'b0, below_word, 1'b0};

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
    lgs_lane u_lane (
      .above     (pad_above[j+2:j]),
      .cur       (pad_cur[j+2:j]),
      .below     (pad_below[j+2:j]),
      .next_cell (lane_out[j])
    );
  end

  // merge lanes, clipped to the active region
  assign row_next = lane_out & col_mask & {MAX_COLS{CFG_W'(wrow) < eff_rows}};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    if (accept) begin
      ram_raddr = (in_word.opcode == OP_ADVANCE) ? '0 : ROW_W'(in_word.row_index);
      if ((in_word.opcode == OP_LOAD) && in_inside) begin
        ram_we    = 1'b1;
        ram_waddr = ROW_W'(in_word.row_index);
        ram_wdata = in_word.row_cells & col_mask;
      end
    end else if (state_r == ST_ADV) begin
      ram_raddr = ROW_W'(k_r + CNT_W'(1));
      if (k_r != '0) begin
        ram_we    = 1'b1;
        ram_waddr = ROW_W'(wrow);
        ram_wdata = row_next;
      end
    end
  end

  lgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      active_rows_r <= CFG_W'(64);
      active_cols_r <= CFG_W'(64);
      row_vld_r     <= '0;
      k_r           <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_ROWS: active_rows_r <= cfg_data;
          CFG_ACTIVE_COLS: active_cols_r <= cfg_data;
        endcase
      end
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_word.opcode)
              OP_ADVANCE: begin
                state_r <= ST_ADV;
                k_r     <= '0;
              end
              OP_READ: begin
                state_r <= ST_RDW;
              end
              default: begin
                out_strobe_r <= 1'b1;
              end
            endcase
          end
        end
        ST_RDW: begin
          out_strobe_r <= 1'b1;
          state_r      <= ST_IDLE;
        end
        ST_ADV: begin
          k_r <= k_r + CNT_W'(1);
          if (k_r == CNT_W'(MAX_ROWS)) begin
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r    <= '0;
      rd_ok_r    <= in_inside && row_vld_r[ROW_W'(in_word.row_index)];
      out_word_r <= '0;
    end else if (state_r == ST_ADV) begin
      cur_r <= below_word;
      if (k_r != '0) begin
        above_r <= cur_r;
      end
      out_word_r <= '0;
    end else if (state_r == ST_RDW) begin
      out_word_r.read_cells   <= rd_ok_r ? (ram_rdata & col_mask) : '0;
      out_word_r.is_read_data <= 1'b1;
    end
  end

endmodule

`default_nettype wire
